FILE: src/smc_pkg.sv
// smc_pkg: shared types, opcodes, status codes and default sizes for the stack machine core
// no dependencies; imported by stack_machine_core and smc_div
`timescale 1ns / 1ps
`default_nettype none

package smc_pkg;

    localparam int WORD_W       = 32;
    localparam int PLEN_W       = 11;
    localparam int DIV_CNT_W    = 6;
    localparam int PROG_DEPTH_D = 1024;
    localparam int DATA_DEPTH_D = 64;
    localparam int CALL_DEPTH_D = 32;

    localparam logic [WORD_W-1:0] OP_MAX = 32'd18;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_EXEC  = 2'd2,
        KIND_SPARE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HALT    = 3'd1,
        ST_FEW     = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_DIVZ    = 3'd4,
        ST_RANGE   = 3'd5,
        ST_INVALID = 3'd6,
        ST_OVER    = 3'd7
    } status_t;

    typedef enum logic [4:0] {
        OP_POP    = 5'd0,
        OP_PUSH   = 5'd1,
        OP_ADD    = 5'd2,
        OP_SUB    = 5'd3,
        OP_MUL    = 5'd4,
        OP_DIV    = 5'd5,
        OP_INC    = 5'd6,
        OP_DEC    = 5'd7,
        OP_DUP    = 5'd8,
        OP_SWAP   = 5'd9,
        OP_PRINT  = 5'd10,
        OP_PRINTC = 5'd11,
        OP_JMP    = 5'd12,
        OP_JZ     = 5'd13,
        OP_JNZ    = 5'd14,
        OP_HALT   = 5'd15,
        OP_CALL   = 5'd16,
        OP_RET    = 5'd17,
        OP_NOP    = 5'd18
    } opcode_t;

endpackage

`default_nettype wire

FILE: src/smc_ram.sv
// smc_ram: generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module smc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/smc_div.sv
// smc_div: signed 32-bit divider, one quotient bit per cycle, truncates toward zero
// depends on smc_pkg
`timescale 1ns / 1ps
`default_nettype none

module smc_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [smc_pkg::WORD_W-1:0]  dividend,
    input  wire logic [smc_pkg::WORD_W-1:0]  divisor,
    output logic                             done,
    output logic      [smc_pkg::WORD_W-1:0]  quotient
);
    import smc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg;
    logic [WORD_W-1:0]    ub_reg;
    logic [WORD_W-1:0]    rem_reg;
    logic [WORD_W-1:0]    quo_reg;
    logic [WORD_W-1:0]    shifted;
    logic [WORD_W:0]      diff;

    // trial subtract of the shifted partial remainder
    assign shifted = {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
    assign diff    = {1'b0, shifted} - {1'b0, ub_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(WORD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath on magnitudes
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
            ub_reg  <= divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
            quo_reg <= dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[WORD_W] ? shifted : diff[WORD_W-1:0];
            quo_reg <= {quo_reg[WORD_W-2:0], ~diff[WORD_W]};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

`default_nettype wire

FILE: src/stack_machine_core.sv
// stack_machine_core: stack processor top level, sequencer around program and stack memories
// depends on smc_pkg, smc_ram, smc_div
`timescale 1ns / 1ps
`default_nettype none

// Stack processor that takes one request at a time: a load writes a program word, a start
// clears the data stack and pc, an execute runs one instruction. Each request returns one
// result with the sticky status, the pc, the word at that pc and any printed value. Program,
// data stack and return stack live in synchronous memories with registered read data;
// an execute reads opcode, operand and the two top stack entries in turn, so its result
// passes through fetch, execute, read-back and output states (swap adds a second write
// state, and div waits in a state of its own on a one-bit-per-cycle divider). Load, start,
// the spare kind, a fetch out of range and an execute while stopped skip fetch and execute.

module stack_machine_core #(
    parameter int PROG_DEPTH = smc_pkg::PROG_DEPTH_D,
    parameter int DATA_DEPTH = smc_pkg::DATA_DEPTH_D,
    parameter int CALL_DEPTH = smc_pkg::CALL_DEPTH_D
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wen,
    input  wire logic [smc_pkg::PLEN_W-1:0]  cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  kind,
    input  wire logic [9:0]                  address,
    input  wire logic [smc_pkg::WORD_W-1:0]  word,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [2:0]                  status,
    output logic      [smc_pkg::WORD_W-1:0]  pc_value,
    output logic      [smc_pkg::WORD_W-1:0]  opcode_seen,
    output logic                             print_valid,
    output logic                             print_as_char,
    output logic      [smc_pkg::WORD_W-1:0]  print_value,
    output logic                             data_stack_empty,
    output logic                             call_stack_empty
);
    import smc_pkg::*;

    localparam int PAW  = $clog2(PROG_DEPTH);
    localparam int DAW  = $clog2(DATA_DEPTH);
    localparam int DCW  = $clog2(DATA_DEPTH + 1);
    localparam int RAW  = $clog2(CALL_DEPTH);
    localparam int RCW  = $clog2(CALL_DEPTH + 1);
    localparam int RETW = $clog2(PROG_DEPTH + 2);
    localparam logic [DCW-1:0] DC_FULL = DCW'(DATA_DEPTH);
    localparam logic [RCW-1:0] RC_FULL = RCW'(CALL_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_F1, S_F2, S_EXEC, S_DIVW, S_SWAP2, S_RD, S_OUT
    } state_t;

    function automatic logic in_range(input logic [WORD_W-1:0] a,
                                      input logic [PLEN_W-1:0] len);
        return (a < WORD_W'(len)) && (a < WORD_W'(PROG_DEPTH));
    endfunction

    state_t              state_reg, state_next;
    logic [PLEN_W-1:0]   plen_reg;
    logic [WORD_W-1:0]   pc_reg, pc_next;
    logic [DCW-1:0]      dc_reg, dc_next;
    logic [RCW-1:0]      rc_reg, rc_next;
    logic [2:0]          stop_reg, stop_next;
    logic [WORD_W-1:0]   op_reg, op_next;
    logic [WORD_W-1:0]   opnd_reg, opnd_next;
    logic [WORD_W-1:0]   top_reg, top_next;
    logic                pv_reg, pv_next;
    logic                pch_reg, pch_next;
    logic [WORD_W-1:0]   pval_reg, pval_next;
    logic                rdok_reg, rdok_next;
    logic                out_valid_reg, out_valid_next;
    logic [2:0]          status_reg;
    logic [WORD_W-1:0]   pcv_reg;
    logic [WORD_W-1:0]   opseen_reg;
    logic                opv_reg;
    logic                opch_reg;
    logic [WORD_W-1:0]   opval_reg;
    logic                dse_reg;
    logic                cse_reg;
    logic                capture;

    logic                pm_we;
    logic [PAW-1:0]      pm_raddr;
    logic [WORD_W-1:0]   pm_rdata;
    logic                ds_we;
    logic [DAW-1:0]      ds_waddr;
    logic [WORD_W-1:0]   ds_wdata;
    logic [DAW-1:0]      ds_raddr;
    logic [WORD_W-1:0]   ds_rdata;
    logic                rs_we;
    logic [RETW-1:0]     rs_rdata;
    logic                div_start;
    logic                div_done;
    logic [WORD_W-1:0]   div_q;

    logic [WORD_W-1:0]   pc_p1, pc_p2;
    logic                r0_ok, r1_ok;
    logic [DCW-1:0]      dc_m1, dc_m2;
    logic [RCW-1:0]      rc_m1;
    logic [WORD_W-1:0]   alu;
    logic                taken;

    assign pc_p1 = pc_reg + 32'd1;
    assign pc_p2 = pc_reg + 32'd2;
    assign r0_ok = in_range(pc_reg, plen_reg);
    assign r1_ok = in_range(pc_p1, plen_reg);
    assign dc_m1 = dc_reg - 1'b1;
    assign dc_m2 = dc_reg - 2'd2;
    assign rc_m1 = rc_reg - 1'b1;

    // memories
    assign pm_we = in_valid && in_ready && (kind == KIND_LOAD)
                   && (WORD_W'(address) < WORD_W'(PROG_DEPTH));
    always_comb
    begin
        case (state_reg)
            S_F1:    pm_raddr = pc_p1[PAW-1:0];
            default: pm_raddr = pc_reg[PAW-1:0];
        endcase
    end
    assign ds_raddr = (state_reg == S_F1) ? dc_m1[DAW-1:0] : dc_m2[DAW-1:0];

    smc_ram #(.WIDTH(WORD_W), .DEPTH(PROG_DEPTH)) u_prog (
        .clk(clk), .we(pm_we), .waddr(PAW'(address)), .wdata(word),
        .raddr(pm_raddr), .rdata(pm_rdata)
    );

    smc_ram #(.WIDTH(WORD_W), .DEPTH(DATA_DEPTH)) u_data (
        .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
        .raddr(ds_raddr), .rdata(ds_rdata)
    );

    smc_ram #(.WIDTH(RETW), .DEPTH(CALL_DEPTH)) u_ret (
        .clk(clk), .we(rs_we), .waddr(rc_reg[RAW-1:0]), .wdata(pc_p2[RETW-1:0]),
        .raddr(rc_m1[RAW-1:0]), .rdata(rs_rdata)
    );

    smc_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(ds_rdata),
        .divisor(top_reg), .done(div_done), .quotient(div_q)
    );

    // arithmetic on second (a) and top (b)
    always_comb
    begin
        case (opcode_t'(op_reg[4:0]))
            OP_ADD:  alu = ds_rdata + top_reg;
            OP_SUB:  alu = ds_rdata - top_reg;
            default: alu = ds_rdata * top_reg;
        endcase
    end

    assign taken = ((opcode_t'(op_reg[4:0]) == OP_JZ) == (top_reg == '0));
    assign in_ready = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        dc_next        = dc_reg;
        rc_next        = rc_reg;
        stop_next      = stop_reg;
        op_next        = op_reg;
        opnd_next      = opnd_reg;
        top_next       = top_reg;
        pv_next        = pv_reg;
        pch_next       = pch_reg;
        pval_next      = pval_reg;
        rdok_next      = rdok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        capture        = 1'b0;
        ds_we          = 1'b0;
        ds_waddr       = dc_m1[DAW-1:0];
        ds_wdata       = top_reg;
        rs_we          = 1'b0;
        div_start      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pv_next    = 1'b0;
                    pch_next   = 1'b0;
                    pval_next  = '0;
                    state_next = S_RD;
                    if (kind == KIND_START)
                    begin
                        dc_next   = '0;
                        pc_next   = '0;
                        stop_next = ST_OK;
                    end
                    else if (kind == KIND_EXEC && stop_reg == ST_OK)
                    begin
                        if (!r0_ok)
                        begin
                            stop_next = ST_RANGE;
                        end
                        else
                        begin
                            state_next = S_F1;
                        end
                    end
                end
            end
            S_F1:
            begin
                op_next    = pm_rdata;
                state_next = S_F2;
            end
            S_F2:
            begin
                opnd_next  = pm_rdata;
                top_next   = ds_rdata;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_RD;
                if (op_reg > OP_MAX)
                begin
                    stop_next = ST_INVALID;
                end
                else
                begin
                    case (opcode_t'(op_reg[4:0]))
                        OP_POP:
                        begin
                            if (dc_reg == '0) stop_next = ST_EMPTY;
                            else
                            begin
                                dc_next = dc_m1;
                                pc_next = pc_p1;
                            end
                        end
                        OP_PUSH:
                        begin
                            if (!r1_ok)
                            begin
                                pc_next   = pc_p1;
                                stop_next = ST_RANGE;
                            end
                            else if (dc_reg >= DC_FULL) stop_next = ST_OVER;
                            else
                            begin
                                ds_we    = 1'b1;
                                ds_waddr = dc_reg[DAW-1:0];
                                ds_wdata = opnd_reg;
                                dc_next  = dc_reg + 1'b1;
                                pc_next  = pc_p2;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL:
                        begin
                            if (dc_reg < DCW'(2)) stop_next = ST_FEW;
                            else
                            begin
                                ds_we    = 1'b1;
                                ds_waddr = dc_m2[DAW-1:0];
                                ds_wdata = alu;
                                dc_next  = dc_m1;
                                pc_next  = pc_p1;
                            end
                        end
                        OP_DIV:
                        begin
                            if (dc_reg < DCW'(2)) stop_next = ST_FEW;
                            else if (top_reg == '0) stop_next = ST_DIVZ;
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIVW;
                            end
                        end
                        OP_INC, OP_DEC:
                        begin
                            if (dc_reg == '0) stop_next = ST_EMPTY;
                            else
                            begin
                                ds_we    = 1'b1;
                                ds_wdata = (opcode_t'(op_reg[4:0]) == OP_INC)
                                           ? top_reg + 32'd1 : top_reg - 32'd1;
                                pc_next  = pc_p1;
                            end
                        end
                        OP_DUP:
                        begin
                            if (dc_reg == '0) stop_next = ST_EMPTY;
                            else if (dc_reg >= DC_FULL) stop_next = ST_OVER;
                            else
                            begin
                                ds_we    = 1'b1;
                                ds_waddr = dc_reg[DAW-1:0];
                                dc_next  = dc_reg + 1'b1;
                                pc_next  = pc_p1;
                            end
                        end
                        OP_SWAP:
                        begin
                            if (dc_reg < DCW'(2)) stop_next = ST_FEW;
                            else
                            begin
                                ds_we      = 1'b1;
                                ds_wdata   = ds_rdata;
                                pc_next    = pc_p1;
                                state_next = S_SWAP2;
                            end
                        end
                        OP_PRINT, OP_PRINTC:
                        begin
                            if (dc_reg == '0) stop_next = ST_EMPTY;
                            else
                            begin
                                dc_next   = dc_m1;
                                pv_next   = 1'b1;
                                pch_next  = (opcode_t'(op_reg[4:0]) == OP_PRINTC);
                                pval_next = top_reg;
                                pc_next   = pc_p1;
                            end
                        end
                        OP_JMP:
                        begin
                            if (!r1_ok)
                            begin
                                pc_next   = pc_p1;
                                stop_next = ST_RANGE;
                            end
                            else pc_next = opnd_reg;
                        end
                        OP_JZ, OP_JNZ:
                        begin
                            if (dc_reg == '0) stop_next = ST_EMPTY;
                            else if (!taken)
                            begin
                                dc_next = dc_m1;
                                pc_next = pc_p2;
                            end
                            else if (!r1_ok)
                            begin
                                pc_next   = pc_p1;
                                stop_next = ST_RANGE;
                            end
                            else
                            begin
                                dc_next = dc_m1;
                                pc_next = opnd_reg;
                            end
                        end
                        OP_HALT:
                        begin
                            stop_next = ST_HALT;
                        end
                        OP_CALL:
                        begin
                            if (!r1_ok)
                            begin
                                pc_next   = pc_p1;
                                stop_next = ST_RANGE;
                            end
                            else if (rc_reg >= RC_FULL) stop_next = ST_OVER;
                            else
                            begin
                                rs_we   = 1'b1;
                                rc_next = rc_reg + 1'b1;
                                pc_next = opnd_reg;
                            end
                        end
                        OP_RET:
                        begin
                            if (rc_reg == '0) stop_next = ST_EMPTY;
                            else
                            begin
                                rc_next = rc_m1;
                                pc_next = WORD_W'(rs_rdata);
                            end
                        end
                        default:
                        begin
                            pc_next = pc_p1;
                        end
                    endcase
                end
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    ds_we      = 1'b1;
                    ds_waddr   = dc_m2[DAW-1:0];
                    ds_wdata   = div_q;
                    dc_next    = dc_m1;
                    pc_next    = pc_p1;
                    state_next = S_RD;
                end
            end
            S_SWAP2:
            begin
                ds_we      = 1'b1;
                ds_waddr   = dc_m2[DAW-1:0];
                ds_wdata   = top_reg;
                state_next = S_RD;
            end
            S_RD:
            begin
                rdok_next  = r0_ok;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    capture        = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            plen_reg      <= '0;
            pc_reg        <= '0;
            dc_reg        <= '0;
            rc_reg        <= '0;
            stop_reg      <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            dc_reg        <= dc_next;
            rc_reg        <= rc_next;
            stop_reg      <= stop_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                plen_reg <= cfg_wdata;
            end
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        opnd_reg <= opnd_next;
        top_reg  <= top_next;
        pv_reg   <= pv_next;
        pch_reg  <= pch_next;
        pval_reg <= pval_next;
        rdok_reg <= rdok_next;
        if (capture)
        begin
            status_reg <= stop_reg;
            pcv_reg    <= pc_reg;
            opseen_reg <= rdok_reg ? pm_rdata : '0;
            opv_reg    <= pv_reg;
            opch_reg   <= pch_reg;
            opval_reg  <= pval_reg;
            dse_reg    <= (dc_reg == '0);
            cse_reg    <= (rc_reg == '0);
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign pc_value         = pcv_reg;
    assign opcode_seen      = opseen_reg;
    assign print_valid      = opv_reg;
    assign print_as_char    = opch_reg;
    assign print_value      = opval_reg;
    assign data_stack_empty = dse_reg;
    assign call_stack_empty = cse_reg;

`ifndef SYNTHESIS
    // stack counts never pass the memory depth
    a_dc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dc_reg <= DC_FULL)
        else $error("data stack count beyond depth");
    a_rc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rc_reg <= RC_FULL)
        else $error("return stack count beyond depth");
    // divider finishes only while the sequencer waits on it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIVW)
        else $error("divider result with no waiting instruction");
    // a stopped machine stays stopped until a start request
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (stop_reg != ST_OK && !(in_valid && in_ready && kind == KIND_START))
        |=> stop_reg == $past(stop_reg))
        else $error("stop status changed without start");
`endif

endmodule

`default_nettype wire
